[src/bit_sequence_store_core_assert.svh]
// ----------------------------------------------------------------------------
// Bit sequence store assertion macros
// Shared concurrent assertion macros for the bit sequence store RTL.
// ----------------------------------------------------------------------------
`ifndef BIT_SEQUENCE_STORE_CORE_ASSERT_SVH
`define BIT_SEQUENCE_STORE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define BSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define BSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`else

`define BSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define BSS_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

[src/bss_pkg.sv]
// ----------------------------------------------------------------------------
// Bit sequence store package
// Operation codes, status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

	localparam int DATA_W = 12;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 13;
	localparam int CNT_W  = 4;
	localparam int CMP_W  = 18;

	localparam logic [MODE_W-1:0] MODE_ADD_BIT     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_BYTE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD_TWELVE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP         = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SET_BIT     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ_BIT    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_READ_BYTE   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_READ_TWELVE = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_FIN
	} seq_state_t;

	function automatic logic [CNT_W-1:0] width_of(input logic [MODE_W-1:0] m);
		logic [CNT_W-1:0] w;
		case (m)
			MODE_ADD_BYTE, MODE_READ_BYTE:     w = 4'd8;
			MODE_ADD_TWELVE, MODE_READ_TWELVE: w = 4'd12;
			default:                           w = 4'd1;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/bss_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/bit_sequence_store_core.sv]
// ----------------------------------------------------------------------------
// Bit sequence store core
// Bit array with a current length: append, pop, set and read bit windows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode, bit_index and value.
//   Output channel (out_valid/out_ready) returns read_data, status and length,
//   one result per input transaction, in order.
//   Each operation walks its bits through the bit RAM (one write port, one read
//   port) one bit per cycle under a small sequencer:
//     append of n bits : n writes in the run state, then the finish state
//     read of n bits   : n reads, finish waits for the registered RAM read
//     set bit          : one write in the run state, then the finish state
//     pop / any error  : straight from idle to the finish state
//   with n = 1, 8 or 12. in_ready is high only while the sequencer is idle.
//   The result sits in an output register, so the next transaction is taken
//   while a finished result still waits; a stalled receiver holds the
//   sequencer only when a second result is ready to be loaded.
//   Reset clears the length to zero; the bit RAM is not cleared and needs no
//   clearing pass, since only bits below the length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_sequence_store_core_assert.svh"

module bit_sequence_store_core #(
	parameter int CAPACITY = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bss_pkg::MODE_W-1:0]  mode,
	input  wire logic [bss_pkg::DATA_W-1:0]  bit_index,
	input  wire logic [bss_pkg::DATA_W-1:0]  value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [bss_pkg::DATA_W-1:0]  read_data,
	output logic      [bss_pkg::STAT_W-1:0]  status,
	output logic      [bss_pkg::LEN_W-1:0]   length
);

	import bss_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [CMP_W-1:0] CAP_W = CMP_W'(CAPACITY);

	seq_state_t state_q, state_d;

	logic [MODE_W-1:0] op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] sh_q;
	logic [DATA_W-1:0] acc_q;
	logic [STAT_W-1:0] stat_q;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     ptr_q;
	logic              rd_pend_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [LEN_W-1:0]  out_len_q;

	logic              accept;
	logic              fin_load;
	logic [CNT_W-1:0]  n_w;
	logic [CMP_W-1:0]  idx_w, len_w, n_ext;
	logic [STAT_W-1:0] chk;
	logic [CNT_W-1:0]  cnt_init;
	logic              op_add, op_set, op_read;
	logic              mem_we, mem_re, mem_wdata, mem_rdata;
	logic [AW-1:0]     mem_waddr;

	assign accept = in_valid && in_ready;
	assign n_w    = width_of(mode);
	assign idx_w  = CMP_W'(bit_index);
	assign len_w  = CMP_W'(len_q);
	assign n_ext  = CMP_W'(n_w);

	always_comb begin
		chk = ST_OK;
		case (mode)
			MODE_ADD_BIT, MODE_ADD_BYTE, MODE_ADD_TWELVE: begin
				if (len_w + n_ext > CAP_W) chk = ST_FULL;
			end
			MODE_POP: begin
				if (len_w == '0) chk = ST_RANGE;
			end
			MODE_SET_BIT: begin
				if (idx_w >= len_w) chk = ST_RANGE;
			end
			default: begin
				if (idx_w + n_ext > len_w) chk = ST_RANGE;
			end
		endcase
	end

	assign cnt_init = (chk == ST_OK && mode != MODE_POP) ? n_w : '0;

	assign op_add  = op_q inside {MODE_ADD_BIT, MODE_ADD_BYTE, MODE_ADD_TWELVE};
	assign op_set  = (op_q == MODE_SET_BIT);
	assign op_read = op_q inside {MODE_READ_BIT, MODE_READ_BYTE, MODE_READ_TWELVE};

	assign fin_load = (state_q == SQ_FIN) && !rd_pend_q && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept) state_d = (cnt_init != '0) ? SQ_RUN : SQ_FIN;
			end
			SQ_RUN: begin
				if (cnt_q == CNT_W'(1)) state_d = SQ_FIN;
			end
			SQ_FIN: begin
				if (fin_load) state_d = SQ_IDLE;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = sh_q[0];
		case (state_q)
			SQ_IDLE: in_ready = 1'b1;
			SQ_RUN: begin
				mem_we = op_add || op_set;
				mem_re = op_read;
				if (op_add) begin
					mem_waddr = len_q[AW-1:0];
					mem_wdata = sh_q[DATA_W-1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= mem_re;
			if (rd_pend_q) begin
				acc_q <= {acc_q[DATA_W-2:0], mem_rdata};
			end
			if (accept) begin
				op_q   <= mode;
				cnt_q  <= cnt_init;
				stat_q <= chk;
				ptr_q  <= idx_w[AW-1:0];
				acc_q  <= '0;
				sh_q   <= (mode == MODE_SET_BIT) ? value
					: DATA_W'(value << (CNT_W'(DATA_W) - n_w));
				if (mode == MODE_POP && chk == ST_OK) begin
					len_q <= len_q - LW'(1);
				end
			end
			if (state_q == SQ_RUN) begin
				cnt_q <= cnt_q - CNT_W'(1);
				ptr_q <= ptr_q + AW'(1);
				sh_q  <= {sh_q[DATA_W-2:0], 1'b0};
				if (op_add) begin
					len_q <= len_q + LW'(1);
				end
			end
			out_valid_q <= fin_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_data_q <= acc_q;
			out_stat_q <= stat_q;
			out_len_q  <= len_w[LEN_W-1:0];
		end
	end

	bss_ram #(
		.WIDTH(1),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(ptr_q),
		.rdata(mem_rdata)
	);

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign status    = out_stat_q;
	assign length    = out_len_q;

	`BSS_ASSERT_ALWAYS(a_len_cap, clk, arst_n, CMP_W'(len_q) <= CAP_W)
	`BSS_ASSERT_IMPL(a_append_room, clk, arst_n, mem_we && op_add, CMP_W'(len_q) < CAP_W)
	`BSS_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && status != ST_OK, read_data == '0)
	`BSS_ASSERT_IMPL(a_run_count, clk, arst_n, state_q == SQ_RUN, cnt_q != '0)

endmodule

`default_nettype wire
